@@ rtl/core/rmq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the rotation matrix to quaternion block.
// Used by the front, the queue, the divider and the top level; depends on nothing.
package rmq_pkg;

    // Which component the square root feeds; AXIS_W means the trace was positive.
    typedef logic [1:0] axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;
    localparam axis_t AXIS_W = 2'd3;

    // The three non-major components run through the divider side by side.
    localparam int LANES = 3;

    // Entries in the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

endpackage

@@ rtl/core/rmq_front.sv @@
`timescale 1ns / 1ps
// Front part: registers one matrix, finds trace sign and major axis, forms the
// clamped radicand and the three element differences. Depends on rmq_pkg.
module rmq_front #(
    parameter int W = 16,
    parameter int F = 14
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic signed [W-1:0]    e00,
    input  logic signed [W-1:0]    e01,
    input  logic signed [W-1:0]    e02,
    input  logic signed [W-1:0]    e10,
    input  logic signed [W-1:0]    e11,
    input  logic signed [W-1:0]    e12,
    input  logic signed [W-1:0]    e20,
    input  logic signed [W-1:0]    e21,
    input  logic signed [W-1:0]    e22,
    output logic                   q_push,
    input  logic                   q_full,
    output logic [3*(W+1)+3+((W > F) ? W : F)+2-1:0] item
);

    localparam int RW  = ((W > F) ? W : F) + 3;
    localparam int DW1 = W + 1;
    localparam int IW  = 3*DW1 + 3 + RW - 1;
    localparam logic [RW-1:0] ONE_V = RW'(1) << F;

    logic                  valid_reg;
    logic                  valid_next;
    logic [IW-1:0]         item_reg;
    logic [IW-1:0]         item_next;
    logic                  load;

    logic signed [RW-1:0]  x00;
    logic signed [RW-1:0]  x11;
    logic signed [RW-1:0]  x22;
    logic signed [RW-1:0]  tr;
    logic signed [RW-1:0]  eii;
    logic signed [RW-1:0]  rad;
    logic [RW-2:0]         rad_c;
    logic                  pos;
    logic                  deg;
    rmq_pkg::axis_t        code;
    logic signed [DW1-1:0] da;
    logic signed [DW1-1:0] db;
    logic signed [DW1-1:0] dc;
    logic signed [DW1-1:0] l0;
    logic signed [DW1-1:0] l1;
    logic signed [DW1-1:0] l2;

    always_comb
    begin
        x00 = RW'(e00);
        x11 = RW'(e11);
        x22 = RW'(e22);
        tr  = x00 + x11 + x22;
        pos = (tr > 0);
        da  = DW1'(e12) - DW1'(e21);
        db  = DW1'(e20) - DW1'(e02);
        dc  = DW1'(e01) - DW1'(e10);

        if (pos)
        begin
            code = rmq_pkg::AXIS_W;
            eii  = x00;
        end
        else if (x22 > ((x11 > x00) ? x11 : x00))
        begin
            code = rmq_pkg::AXIS_Z;
            eii  = x22;
        end
        else if (x11 > x00)
        begin
            code = rmq_pkg::AXIS_Y;
            eii  = x11;
        end
        else
        begin
            code = rmq_pkg::AXIS_X;
            eii  = x00;
        end

        // e[i][i] - e[j][j] - e[k][k] is twice e[i][i] minus the trace.
        if (pos)
            rad = tr + signed'(ONE_V);
        else
            rad = (eii <<< 1) - tr + signed'(ONE_V);
        deg   = !pos && (rad <= 0);
        rad_c = deg ? (RW-1)'(1) : rad[RW-2:0];

        unique case (code)
            rmq_pkg::AXIS_X:
            begin
                l0 = da; l1 = dc; l2 = -db;
            end
            rmq_pkg::AXIS_Y:
            begin
                l0 = db; l1 = da; l2 = -dc;
            end
            rmq_pkg::AXIS_Z:
            begin
                l0 = dc; l1 = db; l2 = -da;
            end
            default:
            begin
                l0 = da; l1 = db; l2 = dc;
            end
        endcase

        item_next = {l0, l1, l2, code, deg, rad_c};
    end

    assign q_push     = valid_reg && !q_full;
    assign in_stall   = valid_reg && q_full;
    assign load       = in_valid && !in_stall;
    assign valid_next = load ? 1'b1 : (q_push ? 1'b0 : valid_reg);
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= item_next;
    end

endmodule

@@ rtl/core/rmq_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue that decouples the front from the arithmetic back end.
// Depends on rmq_pkg for its depth.
module rmq_queue #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);

    localparam int CW = $clog2(rmq_pkg::QUEUE_DEPTH + 1);
    localparam int PW = $clog2(rmq_pkg::QUEUE_DEPTH);

    logic [DATA_W-1:0] mem_reg [rmq_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wptr_reg;
    logic [PW-1:0]     rptr_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;

    assign full    = (count_reg == CW'(rmq_pkg::QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !(rd_en && !empty))
            count_next = count_reg + CW'(1);
        else if (!wr_en && rd_en && !empty)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wptr_reg <= wptr_reg + PW'(1);
            if (rd_en && !empty)
                rptr_reg <= rptr_reg + PW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wptr_reg] <= wr_data;
    end

endmodule

@@ rtl/core/rmq_sqrt.sv @@
`timescale 1ns / 1ps
// Pipelined integer square root, one result bit per stage, with a sideband
// carried alongside. Stand-alone; no package needed.
module rmq_sqrt #(
    parameter int RADW   = 17,
    parameter int FB     = 14,
    parameter int SIDE_W = 8
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [RADW-1:0]             in_rad,
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [(RADW+FB+1)/2-1:0]    out_root,
    output logic [SIDE_W-1:0]           out_side
);

    localparam int SB  = (RADW + FB + 1) / 2;
    localparam int NB  = 2 * SB;
    localparam int RMW = SB + 2;

    logic [NB-1:0]     n_reg    [SB];
    logic [RMW-1:0]    rem_reg  [SB];
    logic [SB-1:0]     root_reg [SB];
    logic [SIDE_W-1:0] side_reg [SB];
    logic              v_reg    [SB];

    logic [NB-1:0]     n_i      [SB];
    logic [RMW-1:0]    rem_i    [SB];
    logic [SB-1:0]     root_i   [SB];
    logic [SIDE_W-1:0] side_i   [SB];
    logic              v_i      [SB];
    logic [RMW-1:0]    rem_sh   [SB];
    logic [RMW-1:0]    trial    [SB];
    logic [RMW-1:0]    rem_nx   [SB];
    logic [SB-1:0]     root_nx  [SB];

    always_comb
    begin
        for (int g = 0; g < SB; g++)
        begin
            if (g == 0)
            begin
                n_i[g]    = NB'(in_rad) << FB;
                rem_i[g]  = '0;
                root_i[g] = '0;
                side_i[g] = in_side;
                v_i[g]    = in_valid;
            end
            else
            begin
                n_i[g]    = n_reg[g-1];
                rem_i[g]  = rem_reg[g-1];
                root_i[g] = root_reg[g-1];
                side_i[g] = side_reg[g-1];
                v_i[g]    = v_reg[g-1];
            end
            rem_sh[g] = {rem_i[g][SB-1:0], n_i[g][NB-1-2*g -: 2]};
            trial[g]  = {root_i[g], 2'b01};
            if (rem_sh[g] >= trial[g])
            begin
                rem_nx[g]  = rem_sh[g] - trial[g];
                root_nx[g] = {root_i[g][SB-2:0], 1'b1};
            end
            else
            begin
                rem_nx[g]  = rem_sh[g];
                root_nx[g] = {root_i[g][SB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < SB; g++)
                v_reg[g] <= 1'b0;
        end
        else if (en)
        begin
            for (int g = 0; g < SB; g++)
                v_reg[g] <= v_i[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < SB; g++)
            begin
                n_reg[g]    <= n_i[g];
                rem_reg[g]  <= rem_nx[g];
                root_reg[g] <= root_nx[g];
                side_reg[g] <= side_i[g];
            end
        end
    end

    assign out_valid = v_reg[SB-1];
    assign out_root  = root_reg[SB-1];
    assign out_side  = side_reg[SB-1];

endmodule

@@ rtl/core/rmq_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage, for the three
// non-major lanes sharing one divisor. Depends on rmq_pkg for the lane count.
module rmq_div #(
    parameter int DW     = 31,
    parameter int VW     = 17,
    parameter int SIDE_W = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  en,
    input  logic                                  in_valid,
    input  logic [rmq_pkg::LANES-1:0][DW-1:0]     in_num,
    input  logic [rmq_pkg::LANES-1:0]             in_neg,
    input  logic [VW-1:0]                         in_den,
    input  logic [SIDE_W-1:0]                     in_side,
    output logic                                  out_valid,
    output logic [rmq_pkg::LANES-1:0][DW-1:0]     out_quo,
    output logic [rmq_pkg::LANES-1:0]             out_neg,
    output logic [SIDE_W-1:0]                     out_side
);

    localparam int L   = rmq_pkg::LANES;
    localparam int RMW = VW + 1;

    logic [L-1:0][DW-1:0]  a_reg    [DW];
    logic [L-1:0][RMW-1:0] rem_reg  [DW];
    logic [L-1:0][DW-1:0]  q_reg    [DW];
    logic [L-1:0]          neg_reg  [DW];
    logic [VW-1:0]         den_reg  [DW];
    logic [SIDE_W-1:0]     side_reg [DW];
    logic                  v_reg    [DW];

    logic [L-1:0][DW-1:0]  a_i      [DW];
    logic [L-1:0][RMW-1:0] rem_i    [DW];
    logic [L-1:0][DW-1:0]  q_i      [DW];
    logic [L-1:0]          neg_i    [DW];
    logic [VW-1:0]         den_i    [DW];
    logic [SIDE_W-1:0]     side_i   [DW];
    logic                  v_i      [DW];
    logic [L-1:0][RMW-1:0] rem_sh   [DW];
    logic [L-1:0][RMW-1:0] rem_nx   [DW];
    logic [L-1:0][DW-1:0]  q_nx     [DW];

    always_comb
    begin
        for (int g = 0; g < DW; g++)
        begin
            if (g == 0)
            begin
                a_i[g]    = in_num;
                rem_i[g]  = '0;
                q_i[g]    = '0;
                neg_i[g]  = in_neg;
                den_i[g]  = in_den;
                side_i[g] = in_side;
                v_i[g]    = in_valid;
            end
            else
            begin
                a_i[g]    = a_reg[g-1];
                rem_i[g]  = rem_reg[g-1];
                q_i[g]    = q_reg[g-1];
                neg_i[g]  = neg_reg[g-1];
                den_i[g]  = den_reg[g-1];
                side_i[g] = side_reg[g-1];
                v_i[g]    = v_reg[g-1];
            end
            for (int l = 0; l < L; l++)
            begin
                rem_sh[g][l] = {rem_i[g][l][VW-1:0], a_i[g][l][DW-1-g]};
                if (rem_sh[g][l] >= {1'b0, den_i[g]})
                begin
                    rem_nx[g][l] = rem_sh[g][l] - {1'b0, den_i[g]};
                    q_nx[g][l]   = {q_i[g][l][DW-2:0], 1'b1};
                end
                else
                begin
                    rem_nx[g][l] = rem_sh[g][l];
                    q_nx[g][l]   = {q_i[g][l][DW-2:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < DW; g++)
                v_reg[g] <= 1'b0;
        end
        else if (en)
        begin
            for (int g = 0; g < DW; g++)
                v_reg[g] <= v_i[g];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int g = 0; g < DW; g++)
            begin
                a_reg[g]    <= a_i[g];
                rem_reg[g]  <= rem_nx[g];
                q_reg[g]    <= q_nx[g];
                neg_reg[g]  <= neg_i[g];
                den_reg[g]  <= den_i[g];
                side_reg[g] <= side_i[g];
            end
        end
    end

    assign out_valid = v_reg[DW-1];
    assign out_quo   = q_reg[DW-1];
    assign out_neg   = neg_reg[DW-1];
    assign out_side  = side_reg[DW-1];

endmodule

@@ rtl/core/rotation_matrix_to_quaternion_top.sv @@
`timescale 1ns / 1ps
// Top level of the rotation matrix to quaternion block.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_sqrt and rmq_div.

// The block takes one 3x3 rotation matrix per transfer and returns the
// quaternion (qx, qy, qz, qw) in the same signed fixed-point format, plus a
// degenerate flag that is set when the matrix is not a rotation and the
// radicand had to be clamped to one LSB. It sustains one matrix per clock
// cycle while no output stall holds the back end. The default format is
// 16-bit Q2.14. Behind the front and the queue, the square-root pipeline
// (one root bit per stage) is followed by the divider pipeline (one quotient
// bit per stage) and the output register. A front stage classifies each
// matrix (trace sign, major axis, radicand, element differences) and hands
// it through a two-entry queue to the arithmetic back end, so input stalls
// and output stalls are decoupled. When out_stall holds the result, the
// back end freezes as a whole and the queue absorbs the items already
// classified before in_stall rises.
module rotation_matrix_to_quaternion_top #(
    parameter int WORD_BITS     = 16,
    parameter int FRACTION_BITS = 14
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [WORD_BITS-1:0]  e00,
    input  logic signed [WORD_BITS-1:0]  e01,
    input  logic signed [WORD_BITS-1:0]  e02,
    input  logic signed [WORD_BITS-1:0]  e10,
    input  logic signed [WORD_BITS-1:0]  e11,
    input  logic signed [WORD_BITS-1:0]  e12,
    input  logic signed [WORD_BITS-1:0]  e20,
    input  logic signed [WORD_BITS-1:0]  e21,
    input  logic signed [WORD_BITS-1:0]  e22,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [WORD_BITS-1:0]  qx,
    output logic signed [WORD_BITS-1:0]  qy,
    output logic signed [WORD_BITS-1:0]  qz,
    output logic signed [WORD_BITS-1:0]  qw,
    output logic                         degenerate
);

    localparam int W    = WORD_BITS;
    localparam int F    = FRACTION_BITS;
    localparam int L    = rmq_pkg::LANES;
    localparam int RW   = ((W > F) ? W : F) + 3;
    localparam int RADW = RW - 1;
    localparam int DW1  = W + 1;
    localparam int IW   = 3*DW1 + 3 + RADW;
    localparam int SQS  = 3*DW1 + 3;
    localparam int SB   = (RADW + F + 1) / 2;
    localparam int DVW  = SB + 1;
    localparam int QW   = W + F + 1;
    localparam int DVS  = SB + 3;
    localparam int CW   = QW + SB + 1;
    localparam logic [CW-1:0] POS_MAX = CW'((64'd1 << (W-1)) - 64'd1);
    localparam logic [CW-1:0] NEG_MAX = CW'(64'd1 << (W-1));

    // Front and queue.
    logic               q_push;
    logic               q_full;
    logic [IW-1:0]      f_item;
    logic [IW-1:0]      q_item;
    logic               q_empty;
    logic               en;

    // The whole back end advances unless the finished result is held.
    assign en = !(out_valid && out_stall);

    rmq_front #(.W(W), .F(F)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .e00      (e00),
        .e01      (e01),
        .e02      (e02),
        .e10      (e10),
        .e11      (e11),
        .e12      (e12),
        .e20      (e20),
        .e21      (e21),
        .e22      (e22),
        .q_push   (q_push),
        .q_full   (q_full),
        .item     (f_item)
    );

    rmq_queue #(.DATA_W(IW)) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (f_item),
        .full    (q_full),
        .rd_en   (en),
        .rd_data (q_item),
        .empty   (q_empty)
    );

    // Square root of radicand times ONE; the sideband carries lanes, axis and degenerate flag.
    logic              sq_valid;
    logic [SB-1:0]     sq_root;
    logic [SQS-1:0]    sq_side;

    rmq_sqrt #(.RADW(RADW), .FB(F), .SIDE_W(SQS)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (!q_empty),
        .in_rad    (q_item[RADW-1:0]),
        .in_side   (q_item[IW-1:RADW]),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Divider inputs: |d| * ONE + s over 2s gives round-half-away division.
    logic [L-1:0][DW1-1:0] lane_d;
    logic [L-1:0][QW-1:0]  lane_num;
    logic [L-1:0]          lane_neg;
    logic [L-1:0][DW1-1:0] lane_mag;
    logic [SB-1:0]         major;
    logic [DVW-1:0]        den;
    logic [DVS-1:0]        dv_side_in;

    always_comb
    begin
        lane_d[0] = sq_side[SQS-1 -: DW1];
        lane_d[1] = sq_side[SQS-1-DW1 -: DW1];
        lane_d[2] = sq_side[SQS-1-2*DW1 -: DW1];
        for (int l = 0; l < L; l++)
        begin
            lane_neg[l] = lane_d[l][DW1-1];
            lane_mag[l] = lane_neg[l] ? (DW1'(0) - lane_d[l]) : lane_d[l];
            lane_num[l] = (QW'(lane_mag[l]) << F) + QW'(sq_root);
        end
        major      = SB'(({1'b0, sq_root} + (SB+1)'(1)) >> 1);
        den        = {sq_root, 1'b0};
        dv_side_in = {major, sq_side[2:0]};
    end

    logic                 dv_valid;
    logic [L-1:0][QW-1:0] dv_quo;
    logic [L-1:0]         dv_neg;
    logic [DVS-1:0]       dv_side;

    rmq_div #(.DW(QW), .VW(DVW), .SIDE_W(DVS)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_num    (lane_num),
        .in_neg    (lane_neg),
        .in_den    (den),
        .in_side   (dv_side_in),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_neg   (dv_neg),
        .out_side  (dv_side)
    );

    // Saturation and placement of the four components.
    logic signed [W-1:0] lane_sat [L];
    logic signed [W-1:0] major_sat;
    rmq_pkg::axis_t      dv_code;
    logic                dv_deg;
    logic signed [W-1:0] qx_next;
    logic signed [W-1:0] qy_next;
    logic signed [W-1:0] qz_next;
    logic signed [W-1:0] qw_next;

    always_comb
    begin
        dv_code = dv_side[2:1];
        dv_deg  = dv_side[0];
        for (int l = 0; l < L; l++)
        begin
            if (dv_neg[l])
            begin
                if (CW'(dv_quo[l]) > NEG_MAX)
                    lane_sat[l] = signed'(NEG_MAX[W-1:0]);
                else
                    lane_sat[l] = signed'(W'(0) - dv_quo[l][W-1:0]);
            end
            else
            begin
                if (CW'(dv_quo[l]) > POS_MAX)
                    lane_sat[l] = signed'(POS_MAX[W-1:0]);
                else
                    lane_sat[l] = signed'(dv_quo[l][W-1:0]);
            end
        end
        if (CW'(dv_side[DVS-1 -: SB]) > POS_MAX)
            major_sat = signed'(POS_MAX[W-1:0]);
        else
            major_sat = signed'(W'(dv_side[DVS-1 -: SB]));

        unique case (dv_code)
            rmq_pkg::AXIS_X:
            begin
                qx_next = major_sat;   qw_next = lane_sat[0];
                qy_next = lane_sat[1]; qz_next = lane_sat[2];
            end
            rmq_pkg::AXIS_Y:
            begin
                qy_next = major_sat;   qw_next = lane_sat[0];
                qz_next = lane_sat[1]; qx_next = lane_sat[2];
            end
            rmq_pkg::AXIS_Z:
            begin
                qz_next = major_sat;   qw_next = lane_sat[0];
                qx_next = lane_sat[1]; qy_next = lane_sat[2];
            end
            default:
            begin
                qw_next = major_sat;   qx_next = lane_sat[0];
                qy_next = lane_sat[1]; qz_next = lane_sat[2];
            end
        endcase
    end

    // Output register; it is the last stage of the back-end pipeline.
    logic                out_valid_reg;
    logic signed [W-1:0] qx_reg;
    logic signed [W-1:0] qy_reg;
    logic signed [W-1:0] qz_reg;
    logic signed [W-1:0] qw_reg;
    logic                deg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            qz_reg  <= qz_next;
            qw_reg  <= qw_next;
            deg_reg <= dv_deg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign qx         = qx_reg;
    assign qy         = qy_reg;
    assign qz         = qz_reg;
    assign qw         = qw_reg;
    assign degenerate = deg_reg;

    // The front never pushes into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue written while full");

    // Input stalls only because the queue is full.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> q_full)
        else $error("input stalled with room in the queue");

    // A frozen back end keeps the root pipeline's output valid unchanged.
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(sq_valid))
        else $error("square-root pipeline moved during output stall");

    // A clamped radicand never comes from the positive-trace path.
    a_deg_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (dv_valid && dv_deg) |-> (dv_code != rmq_pkg::AXIS_W))
        else $error("degenerate flag on positive trace");

endmodule
